// ===== sv/dwm_pkg.sv =====
// ============================================================================
// dwm_pkg: shared types and codes for the deque with middle access
// Command and status codes, the beat payload structs and the cell opcode.
// ============================================================================
package dwm_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;
    localparam int DATA_W   = 32;

    // Command codes carried in the cmd field.
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP_BACK    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PUSH_MIDDLE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_POP_MIDDLE  = 3'd5;

    // Status codes carried in the status field.
    localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
    } cmd_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic signed [DATA_W-1:0] removed_value;
    } rsp_beat_t;

    // The operation that every cell of the row carries out.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_PUSH,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== sv/dwm_cell.sv =====
// ============================================================================
// dwm_cell: one storage cell of the element row
// Holds one element, takes a neighbor's element or the new value on a shift and passes the
// removed element along the read chain toward the front.
// ============================================================================
module dwm_cell #(
    parameter int IDX = 0,
    parameter int PW  = 6
) (
    input  logic                               clk,
    input  dwm_pkg::cell_ctrl_t                ctrl,
    input  logic [PW-1:0]                      pos,
    input  logic signed [dwm_pkg::DATA_W-1:0]  left_data,
    input  logic signed [dwm_pkg::DATA_W-1:0]  right_data,
    input  logic signed [dwm_pkg::DATA_W-1:0]  rem_in,
    output logic signed [dwm_pkg::DATA_W-1:0]  data,
    output logic signed [dwm_pkg::DATA_W-1:0]  rem_out
);

    logic signed [dwm_pkg::DATA_W-1:0] data_reg;
    logic signed [dwm_pkg::DATA_W-1:0] data_next;
    logic                              at_pos;
    logic                              above_pos;

    assign at_pos    = (PW'(IDX) == pos);
    assign above_pos = (PW'(IDX) > pos);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            dwm_pkg::OP_PUSH:
            begin
                if (above_pos)
                begin
                    data_next = left_data;
                end
                else if (at_pos)
                begin
                    data_next = ctrl.value;
                end
            end
            dwm_pkg::OP_POP:
            begin
                if (above_pos || at_pos)
                begin
                    data_next = right_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    // Only the addressed cell contributes to the read chain.
    assign rem_out = at_pos ? (rem_in | data_reg) : rem_in;

endmodule

// ===== sv/deque_with_middle_insert_remove_core.sv =====
// ============================================================================
// deque_with_middle_insert_remove_core: deque with back, front, middle access
// A row of CAPACITY element cells that inserts or removes at any position
// by shifting all later cells in parallel.
// ============================================================================
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements
// and takes one command per beat: push or pop at the back, the front, or
// the middle (index count/2, using the count before the command). Every
// accepted command gives exactly one response beat with a status, the new
// count and the popped element (zero on pushes and ignored commands). A pop
// on an empty list and a push on a full one leave the list unchanged and are
// flagged in the status; unused command codes are answered as done with no
// change. Each command is carried out in the cycle it is accepted: the
// command is broadcast to the row of cells, every cell compares its own
// index with the target position and either holds, takes its lower
// neighbor or the new value (insert) or takes its upper neighbor (remove).
// The popped element travels along an OR chain through the cells to the
// front of the row. The response sits in an output register, and a new
// command is accepted in the same cycle that the pending response is taken,
// so the sustained rate is one command per cycle while responses are taken;
// each response appears in the cycle after its command is accepted. The
// count field holds the low seven bits of the element count. Element
// storage has no reset; only positions below the count are ever read.
// ============================================================================
module deque_with_middle_insert_remove_core #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  dwm_pkg::cmd_beat_t  cmd_data,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output dwm_pkg::rsp_beat_t  rsp_data
);

    localparam int CW          = $clog2(CAPACITY + 1);
    localparam int PW          = $clog2(CAPACITY);
    localparam int COUNT_OUT_W = dwm_pkg::COUNT_W;

    // Element count and response register.
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    dwm_pkg::rsp_beat_t  rsp_data_reg;
    dwm_pkg::rsp_beat_t  rsp_data_next;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    logic [PW-1:0]       pos;
    dwm_pkg::cell_ctrl_t ctrl;
    logic [dwm_pkg::STATUS_W-1:0] status;

    // Row wiring: element outputs and the removed-value chain.
    logic signed [dwm_pkg::DATA_W-1:0] cell_data [CAPACITY];
    logic signed [dwm_pkg::DATA_W-1:0] rem_chain [CAPACITY+1];

    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;
    assign is_full   = (count_reg == CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);

    // Decode the command into a position, a row operation and a status.
    always_comb
    begin
        pos        = '0;
        ctrl.op    = dwm_pkg::OP_HOLD;
        ctrl.value = cmd_data.value;
        status     = dwm_pkg::STATUS_DONE;
        count_next = count_reg;
        case (cmd_data.cmd)
            dwm_pkg::CMD_PUSH_BACK,
            dwm_pkg::CMD_PUSH_FRONT,
            dwm_pkg::CMD_PUSH_MIDDLE:
            begin
                if (cmd_data.cmd == dwm_pkg::CMD_PUSH_BACK)
                begin
                    pos = PW'(count_reg);
                end
                else if (cmd_data.cmd == dwm_pkg::CMD_PUSH_MIDDLE)
                begin
                    pos = PW'(count_reg >> 1);
                end
                if (is_full)
                begin
                    status = dwm_pkg::STATUS_FULL;
                end
                else
                begin
                    ctrl.op    = dwm_pkg::OP_PUSH;
                    count_next = count_reg + CW'(1);
                end
            end
            dwm_pkg::CMD_POP_BACK,
            dwm_pkg::CMD_POP_FRONT,
            dwm_pkg::CMD_POP_MIDDLE:
            begin
                if (cmd_data.cmd == dwm_pkg::CMD_POP_BACK)
                begin
                    pos = PW'(count_reg - CW'(1));
                end
                else if (cmd_data.cmd == dwm_pkg::CMD_POP_MIDDLE)
                begin
                    pos = PW'(count_reg >> 1);
                end
                if (is_empty)
                begin
                    status = dwm_pkg::STATUS_EMPTY;
                end
                else
                begin
                    ctrl.op    = dwm_pkg::OP_POP;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                status = dwm_pkg::STATUS_DONE;
            end
        endcase
        // Nothing moves unless a command beat is taken.
        if (!accept)
        begin
            ctrl.op    = dwm_pkg::OP_HOLD;
            count_next = count_reg;
        end
    end

    assign rem_chain[CAPACITY] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [dwm_pkg::DATA_W-1:0] left_data;
            logic signed [dwm_pkg::DATA_W-1:0] right_data;

            if (gi == 0)
            begin : g_first
                assign left_data = '0;
            end
            else
            begin : g_inner_left
                assign left_data = cell_data[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign right_data = '0;
            end
            else
            begin : g_inner_right
                assign right_data = cell_data[gi+1];
            end

            dwm_cell #(
                .IDX (gi),
                .PW  (PW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .pos        (pos),
                .left_data  (left_data),
                .right_data (right_data),
                .rem_in     (rem_chain[gi+1]),
                .data       (cell_data[gi]),
                .rem_out    (rem_chain[gi])
            );
        end
    endgenerate

    // Response register: loaded on every accepted command beat.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next              = 1'b1;
            rsp_data_next.status        = status;
            rsp_data_next.count         = COUNT_OUT_W'(count_next);
            rsp_data_next.removed_value = (ctrl.op == dwm_pkg::OP_POP) ? rem_chain[0] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule
